// File: sv/mpct_pkg.sv
// shared types, constants and helper functions for the mouse packet cursor tracker
package mpct_pkg;

    // cursor coordinate width
    localparam int COORD_BITS = 12;

    // width of an accelerated motion magnitude: threshold + 256 * 15 stays below 2**13
    localparam int ACC_BITS   = 13;

    // signed working width for position plus motion
    localparam int WIDE_BITS  = ((COORD_BITS > ACC_BITS) ? COORD_BITS : ACC_BITS) + 2;

    localparam int BYTE_BITS  = 8;
    localparam int THR_BITS   = 8;
    localparam int SCALE_BITS = 4;
    localparam int MOVE_X_BITS = 9;
    localparam int MOVE_Y_BITS = 10;
    localparam int BTN_BITS    = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COORD_BITS;

    // output tdata layout, lowest bit first
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + MOVE_X_BITS + MOVE_Y_BITS + BTN_BITS + 2;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    typedef logic        [COORD_BITS-1:0]  coord_t;
    typedef logic signed [WIDE_BITS-1:0]   wide_t;
    typedef logic signed [MOVE_Y_BITS-1:0] move_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;

    // register indexes of the configuration port
    localparam cfg_index_t REG_MIN_X     = 3'd0;
    localparam cfg_index_t REG_MAX_X     = 3'd1;
    localparam cfg_index_t REG_MIN_Y     = 3'd2;
    localparam cfg_index_t REG_MAX_Y     = 3'd3;
    localparam cfg_index_t REG_ACCEL_THR = 3'd4;
    localparam cfg_index_t REG_ACCEL_SCL = 3'd5;

    // reset values
    localparam coord_t MIN_X_RST = coord_t'(0);
    localparam coord_t MAX_X_RST = coord_t'(1024);
    localparam coord_t MIN_Y_RST = coord_t'(0);
    localparam coord_t MAX_Y_RST = coord_t'(768);
    localparam coord_t POS_X_RST = coord_t'((0 + 1024) / 2);
    localparam coord_t POS_Y_RST = coord_t'((0 + 768) / 2);
    localparam logic [THR_BITS-1:0]   THR_RST   = 8'd5;
    localparam logic [SCALE_BITS-1:0] SCALE_RST = 4'd3;

    // acceleration settings shared by both axes
    typedef struct packed {
        logic [THR_BITS-1:0]   threshold;
        logic [SCALE_BITS-1:0] scale;
    } accel_cfg_t;

    // button code from the low three bits of the status byte
    function automatic logic [BTN_BITS-1:0] button_lookup(input logic [2:0] idx);
        logic [BTN_BITS-1:0] code;
        case (idx)
            3'd1:    code = 2'd1;   // left
            3'd2:    code = 2'd3;   // right
            3'd4:    code = 2'd2;   // middle
            default: code = 2'd0;   // none or a combination
        endcase
        return code;
    endfunction

    // clamp to lo first, then to hi, so hi wins when lo exceeds hi
    function automatic coord_t clamp_coord(input wide_t v, input coord_t lo, input coord_t hi);
        wide_t r;
        wide_t lo_w;
        wide_t hi_w;
        r    = v;
        lo_w = wide_t'({{(WIDE_BITS-COORD_BITS){1'b0}}, lo});
        hi_w = wide_t'({{(WIDE_BITS-COORD_BITS){1'b0}}, hi});
        if (r < lo_w)
            r = lo_w;
        if (r > hi_w)
            r = hi_w;
        return r[COORD_BITS-1:0];
    endfunction

    // centre of a range, clamped into it
    function automatic coord_t range_centre(input coord_t lo, input coord_t hi);
        logic [COORD_BITS:0] sum;
        wide_t mid;
        sum = {1'b0, lo} + {1'b0, hi};
        mid = wide_t'({{(WIDE_BITS-COORD_BITS){1'b0}}, sum[COORD_BITS:1]});
        return clamp_coord(mid, lo, hi);
    endfunction

endpackage

// File: sv/mpct_axis.sv
// one cursor axis: motion acceleration, position add and range clamp
module mpct_axis (
    input  mpct_pkg::move_t      move,
    input  mpct_pkg::coord_t     pos,
    input  mpct_pkg::coord_t     lo,
    input  mpct_pkg::coord_t     hi,
    input  mpct_pkg::accel_cfg_t accel,
    output mpct_pkg::coord_t     pos_new
);
    import mpct_pkg::*;

    logic                    neg;
    logic [MOVE_Y_BITS-1:0]  mag;
    logic [MOVE_Y_BITS-1:0]  excess;
    logic [ACC_BITS-1:0]     prod;
    logic [ACC_BITS-1:0]     acc;
    wide_t                   delta;
    wide_t                   sum;

    always_comb
    begin
        neg    = move[MOVE_Y_BITS-1];
        mag    = neg ? (MOVE_Y_BITS'(0) - move) : move;
        excess = mag - MOVE_Y_BITS'(accel.threshold);
        // excess never tops 256, nine bits carry it
        prod   = ACC_BITS'(excess[8:0]) * ACC_BITS'(accel.scale);
        if (mag > MOVE_Y_BITS'(accel.threshold))
            acc = ACC_BITS'(accel.threshold) + prod;
        else
            acc = ACC_BITS'(mag);
        delta  = neg ? (wide_t'(0) - wide_t'({2'b00, acc})) : wide_t'({2'b00, acc});
        sum    = wide_t'({{(WIDE_BITS-COORD_BITS){1'b0}}, pos}) + delta;
    end

    assign pos_new = clamp_coord(sum, lo, hi);

endmodule

// File: sv/mouse_packet_cursor_tracker.sv
// top level of the wheel-mouse packet decoder and cursor tracker
//
// usage
// - slave stream (s_tvalid, s_tready, s_tdata) takes one received mouse byte per
//   transaction; four bytes make a packet: status, dx, dy, wheel
// - a packet whose status byte has bit 7 or 6 set is bad: its first byte is dropped,
//   the next byte slides in and the check is repeated, nothing is sent
// - each good packet gives one master stream transaction (m_tvalid, m_tready,
//   m_tdata) with the clamped cursor position and the decoded packet
// - path: the fourth byte's transaction loads the decode register, which then goes
//   through the acceleration/clamp path into the output register that drives
//   m_tvalid; the move out of the decode register waits while the output is stalled
// - throughput: one byte per cycle; a stalled output holds its data, the decode
//   register keeps the next packet and s_tready drops only when both are full
// - the per-cycle cost is one 9x4 multiply per axis plus add and clamp
// - configuration: cfg_we writes cfg_data into register cfg_index; a write to a
//   range register puts the cursor back at the centre of both ranges
// - reset: ranges 0..1024 and 0..768, threshold 5, scale 3, cursor at the
//   range centres, no byte held, both stream stages empty
module mouse_packet_cursor_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream, tdata: rx_byte[7:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpct_pkg::BYTE_BITS-1:0]      s_tdata,
    // master stream, tdata: cursor_x[11:0], cursor_y[23:12], move_x[32:24],
    // move_y[42:33], button_code[44:43], scroll_up[45], scroll_down[46], zero[47]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mpct_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // configuration write port
    input  logic                                cfg_we,
    input  mpct_pkg::cfg_index_t                cfg_index,
    input  logic [mpct_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mpct_pkg::*;

    // configuration registers
    coord_t       min_x_reg, min_x_next;
    coord_t       max_x_reg, max_x_next;
    coord_t       min_y_reg, min_y_next;
    coord_t       max_y_reg, max_y_next;
    accel_cfg_t   accel_reg, accel_next;
    logic         range_wr;

    // cursor position
    coord_t       pos_x_reg, pos_x_next;
    coord_t       pos_y_reg, pos_y_next;

    // byte collection
    logic [BYTE_BITS-1:0] held_reg [3];
    logic [1:0]           count_reg, count_next;

    // decode stage
    logic                     pkt_valid_reg, pkt_valid_next;
    logic signed [MOVE_X_BITS-1:0] pkt_dx_reg;
    move_t                    pkt_dy_reg;
    logic [BTN_BITS-1:0]      pkt_btn_reg;
    logic                     pkt_wup_reg;
    logic                     pkt_wdn_reg;

    // output stage
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg;

    // handshake
    logic         in_xact;
    logic         out_free;
    logic         pkt_move;
    logic         have_three;
    logic         bad_status;
    logic         good_done;

    // decode of the completing packet
    logic signed [MOVE_X_BITS-1:0] dec_dx;
    move_t                    dec_dy;
    coord_t                   axis_x_new;
    coord_t                   axis_y_new;

    assign out_free   = !out_valid_reg || m_tready;
    assign pkt_move   = pkt_valid_reg && out_free;
    assign s_tready   = !pkt_valid_reg || out_free;
    assign in_xact    = s_tvalid && s_tready;

    assign have_three = (count_reg == 2'd3);
    assign bad_status = (held_reg[0][7:6] != 2'b00);
    assign good_done  = in_xact && have_three && !bad_status;

    // dx is nine-bit two's complement with the sign from status bit 4
    assign dec_dx = {held_reg[0][4], held_reg[1]};
    // dy is 256 - byte when status bit 5 is set, otherwise -byte
    assign dec_dy = {1'b0, held_reg[0][5], 8'h00} - {2'b00, held_reg[2]};

    // configuration decode
    always_comb
    begin
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        accel_next = accel_reg;
        range_wr   = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X:
                begin
                    min_x_next = cfg_data[COORD_BITS-1:0];
                    range_wr   = 1'b1;
                end
                REG_MAX_X:
                begin
                    max_x_next = cfg_data[COORD_BITS-1:0];
                    range_wr   = 1'b1;
                end
                REG_MIN_Y:
                begin
                    min_y_next = cfg_data[COORD_BITS-1:0];
                    range_wr   = 1'b1;
                end
                REG_MAX_Y:
                begin
                    max_y_next = cfg_data[COORD_BITS-1:0];
                    range_wr   = 1'b1;
                end
                REG_ACCEL_THR: accel_next.threshold = cfg_data[THR_BITS-1:0];
                REG_ACCEL_SCL: accel_next.scale     = cfg_data[SCALE_BITS-1:0];
                default: ;  // unknown index, ignored
            endcase
        end
    end

    // one axis unit per coordinate
    mpct_axis u_axis_x (
        .move    (move_t'(pkt_dx_reg)),
        .pos     (pos_x_reg),
        .lo      (min_x_reg),
        .hi      (max_x_reg),
        .accel   (accel_reg),
        .pos_new (axis_x_new)
    );

    mpct_axis u_axis_y (
        .move    (pkt_dy_reg),
        .pos     (pos_y_reg),
        .lo      (min_y_reg),
        .hi      (max_y_reg),
        .accel   (accel_reg),
        .pos_new (axis_y_new)
    );

    // position and stream control
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (range_wr)
        begin
            pos_x_next = range_centre(min_x_next, max_x_next);
            pos_y_next = range_centre(min_y_next, max_y_next);
        end
        else if (pkt_move)
        begin
            pos_x_next = axis_x_new;
            pos_y_next = axis_y_new;
        end

        count_next = count_reg;
        if (in_xact)
        begin
            if (!have_three)
                count_next = count_reg + 2'd1;
            else if (!bad_status)
                count_next = 2'd0;
        end

        pkt_valid_next = pkt_valid_reg;
        if (good_done)
            pkt_valid_next = 1'b1;
        else if (pkt_move)
            pkt_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (pkt_move)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= MIN_X_RST;
            max_x_reg     <= MAX_X_RST;
            min_y_reg     <= MIN_Y_RST;
            max_y_reg     <= MAX_Y_RST;
            accel_reg     <= '{threshold: THR_RST, scale: SCALE_RST};
            pos_x_reg     <= POS_X_RST;
            pos_y_reg     <= POS_Y_RST;
            count_reg     <= 2'd0;
            pkt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            accel_reg     <= accel_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            count_reg     <= count_next;
            pkt_valid_reg <= pkt_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            if (!have_three)
                held_reg[count_reg] <= s_tdata;
            else if (bad_status)
            begin
                // drop the bad status byte and slide the rest down
                held_reg[0] <= held_reg[1];
                held_reg[1] <= held_reg[2];
                held_reg[2] <= s_tdata;
            end
        end

        if (good_done)
        begin
            pkt_dx_reg  <= dec_dx;
            pkt_dy_reg  <= dec_dy;
            pkt_btn_reg <= button_lookup(held_reg[0][2:0]);
            pkt_wup_reg <= s_tdata[7];
            pkt_wdn_reg <= (s_tdata != 8'h00) && !s_tdata[7];
        end

        if (pkt_move)
            out_data_reg <= {{OUT_PAD_BITS{1'b0}}, pkt_wdn_reg, pkt_wup_reg, pkt_btn_reg,
                             pkt_dy_reg, pkt_dx_reg, axis_y_new, axis_x_new};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
